// ----- hdl/isrp_pkg.sv -----
// Shared types and constants for the sensor-hub report parser.
package isrp_pkg;

    localparam int BUFFER_BYTES = 256;
    localparam int REC_DEPTH    = 15;

    localparam logic [14:0] POS_MAX        = 15'h7FFF;
    localparam logic [7:0]  TIMESTAMP_MARK = 8'hFB;
    localparam logic [14:0] TIMESTAMP_SKIP = 15'd5;

    typedef enum logic [3:0] {
        KIND_ACCEL     = 4'd0,
        KIND_GYRO      = 4'd1,
        KIND_MAG       = 4'd2,
        KIND_LINEAR    = 4'd3,
        KIND_GRAVITY   = 4'd4,
        KIND_RV        = 4'd5,
        KIND_GAME_RV   = 4'd6,
        KIND_ARVR_RV   = 4'd7,
        KIND_ARVR_GAME = 4'd8,
        KIND_STEPS     = 4'd9,
        KIND_STABILITY = 4'd10,
        KIND_GYRO_INT  = 4'd11
    } kind_t;

    typedef logic [REC_DEPTH-1:0][7:0] rec_bytes_t;

    typedef struct packed {
        kind_t      kind;
        rec_bytes_t bytes;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

// ----- hdl/isrp_if.sv -----
// Channel interfaces: packet bytes in, decoded reports out.
interface isrp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       packet_start;

    modport source (output valid, output data_byte, output packet_start, input ready);
    modport sink   (input valid, input data_byte, input packet_start, output ready);
endinterface

interface isrp_report_if;
    logic               valid;
    logic               ready;
    logic [3:0]         report_kind;
    logic signed [15:0] value_a;
    logic signed [15:0] value_b;
    logic signed [15:0] value_c;
    logic signed [15:0] value_d;
    logic signed [15:0] value_e;
    logic signed [15:0] value_f;
    logic signed [15:0] value_g;
    logic signed [15:0] accuracy;
    logic [15:0]        count_or_class;
    logic [31:0]        latency;

    modport source (output valid, output report_kind, output value_a, output value_b,
                    output value_c, output value_d, output value_e, output value_f,
                    output value_g, output accuracy, output count_or_class,
                    output latency, input ready);
    modport sink   (input valid, input report_kind, input value_a, input value_b,
                    input value_c, input value_d, input value_e, input value_f,
                    input value_g, input accuracy, input count_or_class,
                    input latency, output ready);
endinterface

// ----- hdl/isrp_front.sv -----
// Front end: header tracking, record gathering and report classification.
module isrp_front
    import isrp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    isrp_byte_if.sink    packet,
    input  q_stat_t      q_stat,
    output logic         push,
    output entry_t       push_entry
);

    localparam logic [14:0] BUF_LIMIT = 15'(BUFFER_BYTES);
    localparam logic [14:0] REC_LAST  = 15'(REC_DEPTH - 1);
    localparam logic [14:0] REC_SIZE  = 15'(REC_DEPTH);
    localparam logic [7:0]  CHAN_CTRL_A = 8'd3;
    localparam logic [7:0]  CHAN_CTRL_B = 8'd4;
    localparam logic [7:0]  CHAN_GYRO   = 8'd5;

    typedef struct packed {
        logic       hit;
        kind_t      kind;
        logic [3:0] last;
        logic [3:0] size;
    } look_t;

    function automatic look_t lookup(input logic [7:0] id);
        look_t r;
        r = '{hit: 1'b1, kind: KIND_ACCEL, last: 4'd9, size: 4'd10};
        unique case (id)
            8'h01:   r.kind = KIND_ACCEL;
            8'h02:   r.kind = KIND_GYRO;
            8'h03:   r.kind = KIND_MAG;
            8'h04:   r.kind = KIND_LINEAR;
            8'h06:   r.kind = KIND_GRAVITY;
            8'h05:   r = '{hit: 1'b1, kind: KIND_RV,        last: 4'd13, size: 4'd14};
            8'h08:   r = '{hit: 1'b1, kind: KIND_GAME_RV,   last: 4'd11, size: 4'd12};
            8'h28:   r = '{hit: 1'b1, kind: KIND_ARVR_RV,   last: 4'd13, size: 4'd14};
            8'h29:   r = '{hit: 1'b1, kind: KIND_ARVR_GAME, last: 4'd11, size: 4'd12};
            8'h11:   r = '{hit: 1'b1, kind: KIND_STEPS,     last: 4'd11, size: 4'd12};
            8'h13:   r = '{hit: 1'b1, kind: KIND_STABILITY, last: 4'd4,  size: 4'd6};
            default: r.hit = 1'b0;
        endcase
        return r;
    endfunction

    logic [14:0] pos_reg, pos_next;
    logic [14:0] len_reg, len_next;
    logic [7:0]  chan_reg, chan_next;
    logic [14:0] rs_reg, rs_next;
    logic        stop_reg, stop_next;
    rec_bytes_t  rec_reg;

    logic        acc;
    logic [7:0]  b;
    logic [14:0] cur_pos, cur_len, cur_rs, p, off, len_hdr;
    logic [7:0]  cur_chan;
    logic        cur_stop;
    logic        wr_en;
    logic [3:0]  wr_idx;
    logic [7:0]  rec_id;
    look_t       look;
    logic [15:0] rs_sum;
    kind_t       push_kind;
    rec_bytes_t  rec_view;

    assign packet.ready = !q_stat.full;
    assign acc = packet.valid && packet.ready;
    assign b   = packet.data_byte;

    always_comb
    begin
        cur_pos  = pos_reg;
        cur_len  = len_reg;
        cur_chan = chan_reg;
        cur_rs   = rs_reg;
        cur_stop = stop_reg;
        if (acc && packet.packet_start)
        begin
            cur_pos  = '0;
            cur_len  = '0;
            cur_chan = '0;
            cur_rs   = '0;
            cur_stop = 1'b0;
        end
        pos_next  = cur_pos;
        len_next  = cur_len;
        chan_next = cur_chan;
        rs_next   = cur_rs;
        stop_next = cur_stop;
        wr_en     = 1'b0;
        wr_idx    = '0;
        push      = 1'b0;
        push_kind = KIND_GYRO_INT;
        p         = cur_pos - 15'd4;
        off       = p - cur_rs;
        len_hdr   = {b[6:0], cur_len[7:0]};
        rec_id    = (off == '0) ? b : rec_reg[0];
        look      = lookup(rec_id);
        rs_sum    = {1'b0, cur_rs} + {12'd0, look.size};

        if (acc && !cur_stop)
        begin
            if (cur_pos != POS_MAX)
                pos_next = cur_pos + 15'd1;
            priority if (cur_pos == 15'd0)
                len_next = {7'd0, b};
            else if (cur_pos == 15'd1)
            begin
                len_next = len_hdr;
                if (len_hdr < 15'd4 || len_hdr > BUF_LIMIT)
                    stop_next = 1'b1;
            end
            else if (cur_pos == 15'd2)
            begin
                chan_next = b;
                if (b != CHAN_CTRL_A && b != CHAN_CTRL_B && b != CHAN_GYRO)
                    stop_next = 1'b1;
            end
            else if (cur_pos == 15'd3)
            begin
                // Sequence byte is not used.
            end
            else if (cur_pos >= cur_len)
                stop_next = 1'b1;
            else if (cur_chan == CHAN_GYRO)
            begin
                if (p < REC_SIZE)
                begin
                    wr_en  = 1'b1;
                    wr_idx = p[3:0];
                end
                if (p == REC_LAST)
                begin
                    push      = 1'b1;
                    push_kind = KIND_GYRO_INT;
                    stop_next = 1'b1;
                end
            end
            else if (p == '0 && b == TIMESTAMP_MARK)
                rs_next = TIMESTAMP_SKIP;
            else if (p < cur_rs)
            begin
                // Still inside a skipped record.
            end
            else if (off >= REC_SIZE)
                stop_next = 1'b1;
            else
            begin
                wr_en  = 1'b1;
                wr_idx = off[3:0];
                if (!look.hit)
                    stop_next = 1'b1;
                else if (off[3:0] == look.last)
                begin
                    push      = 1'b1;
                    push_kind = look.kind;
                    rs_next   = rs_sum[14:0];
                    if (rs_sum[15])
                        stop_next = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        rec_view = rec_reg;
        if (wr_en)
            rec_view[wr_idx] = b;
    end

    assign push_entry = '{kind: push_kind, bytes: rec_view};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            len_reg  <= '0;
            chan_reg <= '0;
            rs_reg   <= '0;
            stop_reg <= 1'b1;
        end
        else
        begin
            pos_reg  <= pos_next;
            len_reg  <= len_next;
            chan_reg <= chan_next;
            rs_reg   <= rs_next;
            stop_reg <= stop_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            rec_reg[wr_idx] <= b;
    end

endmodule

// ----- hdl/isrp_queue.sv -----
// Two-entry queue of classified reports between front and back ends.
module isrp_queue
    import isrp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  entry_t  push_entry,
    input  logic    pop,
    output entry_t  head,
    output q_stat_t q_stat
);

    entry_t      mem_reg [2];
    logic        wr_ptr_reg, rd_ptr_reg;
    logic [1:0]  count_reg;

    assign head         = mem_reg[rd_ptr_reg];
    assign q_stat.full  = (count_reg == 2'd2);
    assign q_stat.empty = (count_reg == 2'd0);

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            unique case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// ----- hdl/isrp_back.sv -----
// Back end: decodes a queued report into its output fields and holds the result.
module isrp_back
    import isrp_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  entry_t         head,
    input  q_stat_t        q_stat,
    output logic           pop,
    isrp_report_if.source  report
);

    logic               valid_reg;
    logic [3:0]         kind_reg;
    logic signed [15:0] a_reg, b_reg, c_reg, d_reg, e_reg, f_reg, g_reg, acc_reg;
    logic [15:0]        cnt_reg;
    logic [31:0]        lat_reg;

    logic signed [15:0] a_next, b_next, c_next, d_next, e_next, f_next, g_next, acc_next;
    logic [15:0]        cnt_next;
    logic [31:0]        lat_next;
    rec_bytes_t         r;

    assign r   = head.bytes;
    assign pop = !q_stat.empty && (!valid_reg || report.ready);

    always_comb
    begin
        a_next   = '0;
        b_next   = '0;
        c_next   = '0;
        d_next   = '0;
        e_next   = '0;
        f_next   = '0;
        g_next   = '0;
        acc_next = '0;
        cnt_next = '0;
        lat_next = '0;
        unique case (head.kind)
            KIND_ACCEL, KIND_GYRO, KIND_MAG, KIND_LINEAR, KIND_GRAVITY:
            begin
                a_next   = {r[5], r[4]};
                b_next   = {r[7], r[6]};
                c_next   = {r[9], r[8]};
                acc_next = {8'd0, r[2]};
            end
            KIND_RV, KIND_GAME_RV, KIND_ARVR_RV, KIND_ARVR_GAME:
            begin
                a_next = {r[5], r[4]};
                b_next = {r[7], r[6]};
                c_next = {r[9], r[8]};
                d_next = {r[11], r[10]};
                if (head.kind == KIND_RV || head.kind == KIND_ARVR_RV)
                    acc_next = {r[13], r[12]};
            end
            KIND_STEPS:
            begin
                cnt_next = {r[9], r[8]};
                lat_next = {r[7], r[6], r[5], r[4]};
            end
            KIND_STABILITY:
                cnt_next = {8'd0, r[4]};
            KIND_GYRO_INT:
            begin
                a_next = {r[2], r[1]};
                b_next = {r[4], r[3]};
                c_next = {r[6], r[5]};
                d_next = {r[8], r[7]};
                g_next = {r[10], r[9]};
                e_next = {r[12], r[11]};
                f_next = {r[14], r[13]};
            end
            default:
            begin
                a_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (pop)
            valid_reg <= 1'b1;
        else if (report.ready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            kind_reg <= head.kind;
            a_reg    <= a_next;
            b_reg    <= b_next;
            c_reg    <= c_next;
            d_reg    <= d_next;
            e_reg    <= e_next;
            f_reg    <= f_next;
            g_reg    <= g_next;
            acc_reg  <= acc_next;
            cnt_reg  <= cnt_next;
            lat_reg  <= lat_next;
        end
    end

    assign report.valid          = valid_reg;
    assign report.report_kind    = kind_reg;
    assign report.value_a        = a_reg;
    assign report.value_b        = b_reg;
    assign report.value_c        = c_reg;
    assign report.value_d        = d_reg;
    assign report.value_e        = e_reg;
    assign report.value_f        = f_reg;
    assign report.value_g        = g_reg;
    assign report.accuracy       = acc_reg;
    assign report.count_or_class = cnt_reg;
    assign report.latency        = lat_reg;

endmodule

// ----- hdl/imu_sensor_report_parser_top.sv -----
// Top level of the sensor-hub transport packet report parser.
//
// The packet channel takes one byte per request, header first, with packet_start
// set on the first header byte. A byte is taken at a rising edge where valid and
// ready are both high. The report channel gives one request for each decoded
// sensor report, carrying raw signed fixed-point values exactly as they sit in
// the packet.
// Throughput is one byte per cycle. The front end classifies each byte in the
// cycle it arrives, so ready stays high unless two decoded reports are already
// waiting in the two-entry queue behind a stalled receiver.
// The byte that completes a report enters the queue at its accepting edge, and
// the back end loads the decoded fields from the queue into the output register
// once that register is free or being taken.
// When the receiver stalls, the output register holds its report and the queue
// absorbs up to two more; after that, packet ready drops until space opens up.
// After reset the parser ignores all bytes until it sees a packet start, and the
// queue and output register are empty.
module imu_sensor_report_parser_top
    import isrp_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    isrp_byte_if.sink     packet,
    isrp_report_if.source report
);

    logic    q_push;
    logic    q_pop;
    entry_t  q_entry;
    entry_t  q_head;
    q_stat_t q_stat;

    // Header tracking and report classification, one byte per cycle while the queue has room.
    isrp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .packet     (packet),
        .q_stat     (q_stat),
        .push       (q_push),
        .push_entry (q_entry)
    );

    // Decouples the byte stream from stalls on the report channel.
    isrp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .pop        (q_pop),
        .head       (q_head),
        .q_stat     (q_stat)
    );

    // Field decoding and the output register.
    isrp_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (q_head),
        .q_stat (q_stat),
        .pop    (q_pop),
        .report (report)
    );

    // A report is only ever queued when there is room for it.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_stat.full)
        else $error("report queued while the queue is full");

    // Reports come only from accepted bytes.
    a_push_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> (packet.valid && packet.ready))
        else $error("report queued without an accepted byte");

    // A waiting report reaches an empty output register on the next cycle.
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (!q_stat.empty && !report.valid) |=> report.valid)
        else $error("queued report not moved to the output register");

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the sensor-hub transport packet report parser.
module testbench;
    import isrp_pkg::*;

    // The run is cut short here if the parser stops making progress. The slowest
    // correct run is roughly 1700 bytes at the slowest send pace plus result stalls
    // and the long hold-off, well under a tenth of this.
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_BYTES = 900;
    localparam int MAX_PRINTS   = 40;

    // Transport channels. Only the two report channels and the gyro-integrated
    // rotation channel carry anything the parser decodes.
    localparam logic [7:0] CH_CONTROL      = 8'd2;
    localparam logic [7:0] CH_REPORTS      = 8'd3;
    localparam logic [7:0] CH_WAKE_REPORTS = 8'd4;
    localparam logic [7:0] CH_GYRO_ROT     = 8'd5;

    // Sensor report identifiers as they appear in the first byte of a report.
    localparam logic [7:0] ID_ACCEL     = 8'h01;
    localparam logic [7:0] ID_GYRO      = 8'h02;
    localparam logic [7:0] ID_MAG       = 8'h03;
    localparam logic [7:0] ID_LINEAR    = 8'h04;
    localparam logic [7:0] ID_RV        = 8'h05;
    localparam logic [7:0] ID_GRAVITY   = 8'h06;
    localparam logic [7:0] ID_GAME_RV   = 8'h08;
    localparam logic [7:0] ID_STEPS     = 8'h11;
    localparam logic [7:0] ID_STABILITY = 8'h13;
    localparam logic [7:0] ID_ARVR_RV   = 8'h28;
    localparam logic [7:0] ID_ARVR_GAME = 8'h29;

    // How often a side sits idle between requests.
    typedef enum int {PACE_NONE, PACE_FULL, PACE_SPARSE} pace_t;

    // Byte patterns for report bodies. The minimum and maximum patterns put
    // 0x8000 and 0x7FFF into every little-endian word at an even offset.
    typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES, FILL_MIN, FILL_MAX} fill_t;

    typedef struct packed {
        kind_t              kind;
        logic signed [15:0] value_a;
        logic signed [15:0] value_b;
        logic signed [15:0] value_c;
        logic signed [15:0] value_d;
        logic signed [15:0] value_e;
        logic signed [15:0] value_f;
        logic signed [15:0] value_g;
        logic signed [15:0] accuracy;
        logic [15:0]        count_or_class;
        logic [31:0]        latency;
    } report_t;

    logic clk = 1'b0;
    logic rst_n;

    isrp_byte_if   byte_ch ();
    isrp_report_if report_ch ();

    imu_sensor_report_parser_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .packet (byte_ch),
        .report (report_ch)
    );

    always #2 clk = ~clk;

    // Shadow copy of the parser's packet state, advanced once per accepted byte.
    logic [14:0] hub_pos    = '0;
    logic [14:0] hub_len    = '0;
    logic [7:0]  hub_chan   = '0;
    int          rec_base   = 0;
    logic [7:0]  rec_buf [REC_DEPTH];
    bit          hub_idle   = 1'b1;

    // Decoded reports still owed by the parser, oldest first.
    report_t     pending_reports [$];

    // Payload of the packet being built by the stimulus tasks.
    logic [7:0]  payload [$];

    pace_t       send_pace    = PACE_NONE;
    pace_t       take_pace    = PACE_NONE;
    int          hold_request = 0;
    int          hold_left    = 0;
    int          stall_left   = 0;
    int          mismatches   = 0;
    int          cycle_count  = 0;

    // Maps a report id to its kind, the offset of its last needed byte and its
    // size in the packet. Returns 0 for an id the parser does not know.
    function automatic bit report_shape(input logic [7:0] id, output kind_t kind,
                                        output int last_off, output int size);
        kind = KIND_ACCEL;
        last_off = 0;
        size = 0;
        case (id)
            ID_ACCEL:     begin kind = KIND_ACCEL;     last_off = 9;  size = 10; end
            ID_GYRO:      begin kind = KIND_GYRO;      last_off = 9;  size = 10; end
            ID_MAG:       begin kind = KIND_MAG;       last_off = 9;  size = 10; end
            ID_LINEAR:    begin kind = KIND_LINEAR;    last_off = 9;  size = 10; end
            ID_GRAVITY:   begin kind = KIND_GRAVITY;   last_off = 9;  size = 10; end
            ID_RV:        begin kind = KIND_RV;        last_off = 13; size = 14; end
            ID_GAME_RV:   begin kind = KIND_GAME_RV;   last_off = 11; size = 12; end
            ID_ARVR_RV:   begin kind = KIND_ARVR_RV;   last_off = 13; size = 14; end
            ID_ARVR_GAME: begin kind = KIND_ARVR_GAME; last_off = 11; size = 12; end
            ID_STEPS:     begin kind = KIND_STEPS;     last_off = 11; size = 12; end
            ID_STABILITY: begin kind = KIND_STABILITY; last_off = 4;  size = 6;  end
            default:      return 1'b0;
        endcase
        return 1'b1;
    endfunction

    function automatic logic [15:0] rec_word(input int k);
        return {rec_buf[k + 1], rec_buf[k]};
    endfunction

    // Advances the shadow state by one accepted byte and queues the report that
    // the byte completes, if any.
    function automatic void track_byte(input logic [7:0] b, input bit start);
        logic [14:0] pos;
        int          p;
        int          off;
        int          last_off;
        int          size;
        kind_t       kind;
        report_t     r;

        if (start) begin
            hub_pos  = '0;
            hub_len  = '0;
            hub_chan = '0;
            rec_base = 0;
            hub_idle = 1'b0;
        end
        if (hub_idle)
            return;

        pos = hub_pos;
        if (hub_pos < POS_MAX)
            hub_pos = hub_pos + 15'd1;

        // Header: two length bytes (bit 15 dropped), channel, then sequence.
        if (pos == 15'd0) begin
            hub_len = {7'd0, b};
            return;
        end
        if (pos == 15'd1) begin
            hub_len = {b[6:0], hub_len[7:0]};
            if (hub_len < 15'd4 || int'(hub_len) > BUFFER_BYTES)
                hub_idle = 1'b1;
            return;
        end
        if (pos == 15'd2) begin
            hub_chan = b;
            if (b != CH_REPORTS && b != CH_WAKE_REPORTS && b != CH_GYRO_ROT)
                hub_idle = 1'b1;
            return;
        end
        if (pos == 15'd3)
            return;
        if (pos >= hub_len) begin
            hub_idle = 1'b1;
            return;
        end
        p = int'(pos) - 4;

        // The gyro-integrated channel yields one report from payload bytes 1..14.
        if (hub_chan == CH_GYRO_ROT) begin
            if (p < REC_DEPTH)
                rec_buf[p] = b;
            if (p == REC_DEPTH - 1) begin
                r = '0;
                r.kind    = KIND_GYRO_INT;
                r.value_a = rec_word(1);
                r.value_b = rec_word(3);
                r.value_c = rec_word(5);
                r.value_d = rec_word(7);
                r.value_g = rec_word(9);
                r.value_e = rec_word(11);
                r.value_f = rec_word(13);
                pending_reports.push_back(r);
                hub_idle = 1'b1;
            end
            return;
        end

        // A timestamp record may only lead the payload.
        if (p == 0 && b == TIMESTAMP_MARK) begin
            rec_base = int'(TIMESTAMP_SKIP);
            return;
        end
        if (p < rec_base)
            return;
        off = p - rec_base;
        if (off >= REC_DEPTH) begin
            hub_idle = 1'b1;
            return;
        end
        rec_buf[off] = b;
        if (!report_shape(rec_buf[0], kind, last_off, size)) begin
            hub_idle = 1'b1;
            return;
        end
        if (off != last_off)
            return;

        r = '0;
        r.kind = kind;
        if (kind <= KIND_GRAVITY) begin
            r.value_a  = rec_word(4);
            r.value_b  = rec_word(6);
            r.value_c  = rec_word(8);
            r.accuracy = {8'd0, rec_buf[2]};
        end else if (kind <= KIND_ARVR_GAME) begin
            r.value_a = rec_word(4);
            r.value_b = rec_word(6);
            r.value_c = rec_word(8);
            r.value_d = rec_word(10);
            if (kind == KIND_RV || kind == KIND_ARVR_RV)
                r.accuracy = rec_word(12);
        end else if (kind == KIND_STEPS) begin
            r.count_or_class = rec_word(8);
            r.latency        = {rec_buf[7], rec_buf[6], rec_buf[5], rec_buf[4]};
        end else begin
            r.count_or_class = {8'd0, rec_buf[4]};
        end
        pending_reports.push_back(r);
        rec_base = rec_base + size;
        if (rec_base > int'(POS_MAX))
            hub_idle = 1'b1;
    endfunction

    function automatic int draw_wait(input pace_t pace);
        case (pace)
            PACE_NONE: return 0;
            PACE_FULL: return $urandom_range(0, 15);
            default:   return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 15) : 0;
        endcase
    endfunction

    function automatic logic [7:0] fill_byte(input fill_t fill, input int j);
        case (fill)
            FILL_ZERO: return 8'h00;
            FILL_ONES: return 8'hFF;
            FILL_MIN:  return (j % 2 == 1) ? 8'h80 : 8'h00;
            FILL_MAX:  return (j % 2 == 1) ? 8'h7F : 8'hFF;
            default:   return 8'($urandom);
        endcase
    endfunction

    // The first five ids are the three-axis reports.
    function automatic logic [7:0] pick_id(input int n);
        case (n)
            0:       return ID_ACCEL;
            1:       return ID_GYRO;
            2:       return ID_MAG;
            3:       return ID_LINEAR;
            4:       return ID_GRAVITY;
            5:       return ID_RV;
            6:       return ID_GAME_RV;
            7:       return ID_ARVR_RV;
            8:       return ID_ARVR_GAME;
            9:       return ID_STEPS;
            default: return ID_STABILITY;
        endcase
    endfunction

    function automatic logic [7:0] unknown_id();
        logic [7:0] id;
        kind_t      kind;
        int         last_off;
        int         size;
        do
            id = 8'($urandom);
        while (report_shape(id, kind, last_off, size));
        return id;
    endfunction

    function automatic void add_report(input logic [7:0] id, input fill_t fill);
        kind_t kind;
        int    last_off;
        int    size;
        void'(report_shape(id, kind, last_off, size));
        payload.push_back(id);
        for (int j = 1; j < size; j++)
            payload.push_back(fill_byte(fill, j));
    endfunction

    function automatic void add_timestamp();
        payload.push_back(TIMESTAMP_MARK);
        repeat (4) payload.push_back(8'($urandom));
    endfunction

    // Gyro-integrated words sit at odd payload offsets, hence the shifted index.
    function automatic void add_gyro_payload(input fill_t fill, input int n);
        for (int j = 0; j < n; j++)
            payload.push_back(fill_byte(fill, j + 1));
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= MAX_PRINTS)
                $display("%0t ns: %s expected %h, got %h", $time, name, want, got);
        end
    endfunction

    // Offers one byte as a request after a random pause and returns at the
    // rising edge where it is taken. Valid stays high on return so that a
    // following byte with no pause goes out back to back.
    task automatic send_byte(input logic [7:0] b, input bit start);
        int gap;
        gap = draw_wait(send_pace);
        @(negedge clk);
        if (gap > 0) begin
            byte_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        byte_ch.valid        <= 1'b1;
        byte_ch.data_byte    <= b;
        byte_ch.packet_start <= start;
        @(posedge clk);
        while (!byte_ch.ready)
            @(posedge clk);
        track_byte(b, start);
    endtask

    // Sends a header with the given length and channel, then the first count
    // bytes of the payload (all of it when count is negative). Bit 15 of the
    // length is random since the parser must ignore it.
    task automatic send_frame(input int len, input logic [7:0] chan, input int count);
        logic [14:0] len_bits;
        int          n;
        len_bits = len[14:0];
        n = (count < 0 || count > payload.size()) ? payload.size() : count;
        send_byte(len_bits[7:0], 1'b1);
        send_byte({1'($urandom), len_bits[14:8]}, 1'b0);
        send_byte(chan, 1'b0);
        send_byte(8'($urandom), 1'b0);
        for (int i = 0; i < n; i++)
            send_byte(payload[i], 1'b0);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        byte_ch.valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
    endtask

    // Bytes that arrive before any packet start must be dropped silently.
    task automatic test_idle_bytes();
        send_pace = PACE_SPARSE;
        repeat (6) send_byte(8'($urandom), 1'b0);
    endtask

    // Every report-channel kind at least once, with the extreme word values spread across them.
    task automatic test_sensor_reports();
        send_pace = PACE_NONE;
        take_pace = PACE_NONE;
        payload.delete();
        add_report(ID_ACCEL, FILL_MIN);
        add_report(ID_GYRO, FILL_MAX);
        add_report(ID_MAG, FILL_ZERO);
        add_report(ID_LINEAR, FILL_ONES);
        add_report(ID_GRAVITY, FILL_RANDOM);
        send_frame(4 + payload.size(), CH_REPORTS, -1);

        // The wake channel packet leads with a timestamp record to be skipped.
        payload.delete();
        add_timestamp();
        add_report(ID_RV, FILL_MIN);
        add_report(ID_GAME_RV, FILL_MAX);
        add_report(ID_ARVR_RV, FILL_ONES);
        add_report(ID_ARVR_GAME, FILL_ZERO);
        add_report(ID_STEPS, FILL_ONES);
        add_report(ID_STABILITY, FILL_MAX);
        add_report(ID_STEPS, FILL_MIN);
        send_frame(4 + payload.size(), CH_WAKE_REPORTS, -1);
        wait_drained();
    endtask

    // Gyro-integrated packets: exactly 15 payload bytes, extra trailing bytes,
    // and one byte short, which must give nothing.
    task automatic test_gyro_integrated();
        send_pace = PACE_SPARSE;
        take_pace = PACE_FULL;
        payload.delete();
        add_gyro_payload(FILL_MIN, 15);
        send_frame(19, CH_GYRO_ROT, -1);
        payload.delete();
        add_gyro_payload(FILL_MAX, 18);
        send_frame(22, CH_GYRO_ROT, -1);
        payload.delete();
        add_gyro_payload(FILL_RANDOM, 14);
        send_frame(18, CH_GYRO_ROT, -1);
        wait_drained();
    endtask

    // Packets that the parser has to drop in whole or in part.
    task automatic test_broken_packets();
        send_pace = PACE_FULL;
        take_pace = PACE_SPARSE;

        // Lengths below the header size and above the buffer are ignored.
        payload.delete();
        add_report(ID_ACCEL, FILL_RANDOM);
        send_frame(3, CH_REPORTS, -1);
        send_frame(BUFFER_BYTES + 1, CH_REPORTS, -1);

        // A header-only packet: every payload byte lies past the length.
        send_frame(4, CH_REPORTS, -1);

        // A channel outside the report channels is ignored.
        send_frame(4 + payload.size(), CH_CONTROL, -1);

        // An unknown id ends the packet; a timestamp mark that does not lead
        // the payload counts as unknown.
        payload.delete();
        add_report(ID_GYRO, FILL_RANDOM);
        payload.push_back(unknown_id());
        payload.push_back(8'($urandom));
        add_report(ID_ACCEL, FILL_RANDOM);
        send_frame(4 + payload.size(), CH_REPORTS, -1);
        payload.delete();
        add_report(ID_MAG, FILL_RANDOM);
        add_timestamp();
        add_report(ID_ACCEL, FILL_RANDOM);
        send_frame(4 + payload.size(), CH_WAKE_REPORTS, -1);

        // A report cut off by the length, with the rest sent past the length.
        payload.delete();
        add_report(ID_MAG, FILL_RANDOM);
        add_report(ID_STEPS, FILL_RANDOM);
        send_frame(20, CH_REPORTS, -1);

        // Rotation vectors that lack their accuracy word.
        payload.delete();
        add_report(ID_RV, FILL_RANDOM);
        send_frame(16, CH_REPORTS, -1);
        payload.delete();
        add_report(ID_ARVR_RV, FILL_RANDOM);
        send_frame(17, CH_WAKE_REPORTS, -1);

        // A timestamp with nothing after it.
        payload.delete();
        add_timestamp();
        send_frame(9, CH_REPORTS, -1);

        // A packet abandoned halfway by the next packet start.
        payload.delete();
        add_report(ID_ACCEL, FILL_RANDOM);
        add_report(ID_GYRO, FILL_RANDOM);
        send_frame(4 + payload.size(), CH_REPORTS, 15);
        payload.delete();
        add_report(ID_GRAVITY, FILL_RANDOM);
        send_frame(4 + payload.size(), CH_REPORTS, -1);
        wait_drained();
    endtask

    // A full-size packet of back-to-back reports while the receiver holds off
    // for a long stretch: the report queue fills and packet ready must drop.
    task automatic test_backpressure();
        send_pace = PACE_NONE;
        take_pace = PACE_NONE;
        @(posedge clk);
        hold_request = 150;
        payload.delete();
        repeat (25) add_report(pick_id($urandom_range(0, 4)), FILL_RANDOM);
        payload.push_back(ID_STABILITY);
        payload.push_back(8'($urandom));
        send_frame(BUFFER_BYTES, CH_REPORTS, -1);
        wait_drained();
    endtask

    // Mostly well-formed packets with random content, the rest broken ones.
    task automatic test_random_traffic();
        int         sent;
        int         roll;
        int         len;
        logic [7:0] chan;
        sent = 0;
        while (sent < RANDOM_BYTES) begin
            if ($urandom_range(0, 9) == 0) begin
                send_pace = pace_t'($urandom_range(0, 2));
                take_pace = pace_t'($urandom_range(0, 2));
            end
            payload.delete();
            roll = $urandom_range(0, 99);
            if (roll < 65) begin
                if ($urandom_range(0, 1) == 1)
                    add_timestamp();
                repeat ($urandom_range(1, 4)) add_report(pick_id($urandom_range(0, 10)),
                                                         FILL_RANDOM);
                send_frame(4 + payload.size(),
                           ($urandom_range(0, 1) == 1) ? CH_REPORTS : CH_WAKE_REPORTS, -1);
                sent += 4 + payload.size();
            end else if (roll < 77) begin
                add_gyro_payload(FILL_RANDOM, $urandom_range(13, 22));
                send_frame(4 + payload.size(), CH_GYRO_ROT, -1);
                sent += 4 + payload.size();
            end else if (roll < 88) begin
                if ($urandom_range(0, 1) == 1)
                    add_timestamp();
                repeat ($urandom_range(1, 3)) add_report(pick_id($urandom_range(0, 10)),
                                                         FILL_RANDOM);
                chan = ($urandom_range(0, 1) == 1) ? CH_REPORTS : CH_WAKE_REPORTS;
                case ($urandom_range(0, 2))
                    0: begin
                        payload.push_back(unknown_id());
                        add_report(pick_id($urandom_range(0, 10)), FILL_RANDOM);
                        send_frame(4 + payload.size(), chan, -1);
                    end
                    1: send_frame(4 + $urandom_range(1, payload.size() - 1), chan, -1);
                    default: send_frame(4 + payload.size(), chan,
                                        $urandom_range(0, payload.size() - 1));
                endcase
                sent += 4 + payload.size();
            end else if (roll < 94) begin
                repeat ($urandom_range(0, 8)) payload.push_back(8'($urandom));
                len = ($urandom_range(0, 1) == 1) ? $urandom_range(0, 3)
                                                  : $urandom_range(BUFFER_BYTES + 1, 32767);
                send_frame(len, CH_REPORTS, -1);
            end else begin
                add_report(pick_id($urandom_range(0, 10)), FILL_RANDOM);
                do
                    chan = 8'($urandom);
                while (chan == CH_REPORTS || chan == CH_WAKE_REPORTS || chan == CH_GYRO_ROT);
                send_frame(4 + payload.size(), chan, -1);
            end
        end
    endtask

    // Receiver: holds ready low for the stall drawn after each report, and for
    // the long hold-off when a test asks for one.
    initial begin
        report_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                report_ch.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                report_ch.ready <= 1'b0;
            end else begin
                report_ch.ready <= 1'b1;
            end
        end
    end

    // Every report taken is compared field by field with the oldest one owed.
    always @(posedge clk) begin : report_check
        report_t want;
        if (report_ch.valid && report_ch.ready) begin
            if (pending_reports.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_PRINTS)
                    $display("%0t ns: report expected none, got kind %0d",
                             $time, report_ch.report_kind);
            end else begin
                want = pending_reports.pop_front();
                check_field("report_kind", want.kind, report_ch.report_kind);
                check_field("value_a", want.value_a, report_ch.value_a);
                check_field("value_b", want.value_b, report_ch.value_b);
                check_field("value_c", want.value_c, report_ch.value_c);
                check_field("value_d", want.value_d, report_ch.value_d);
                check_field("value_e", want.value_e, report_ch.value_e);
                check_field("value_f", want.value_f, report_ch.value_f);
                check_field("value_g", want.value_g, report_ch.value_g);
                check_field("accuracy", want.accuracy, report_ch.accuracy);
                check_field("count_or_class", want.count_or_class,
                            report_ch.count_or_class);
                check_field("latency", want.latency, report_ch.latency);
            end
            stall_left = draw_wait(take_pace);
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Main sequence: one reset, then each test in turn, then a drain.
    initial begin
        byte_ch.valid        = 1'b0;
        byte_ch.data_byte    = 8'd0;
        byte_ch.packet_start = 1'b0;
        for (int i = 0; i < REC_DEPTH; i++)
            rec_buf[i] = 8'd0;
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_idle_bytes();
        test_sensor_reports();
        test_gyro_integrated();
        test_broken_packets();
        test_backpressure();
        test_random_traffic();

        // Anything the parser still owes must come out once the queue has drained;
        // the wait that follows catches any extra reports.
        wait_drained();
        repeat (10) @(posedge clk);
        if (mismatches == 0 && pending_reports.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ----- imu_sensor_report_parser_top.f -----
hdl/isrp_pkg.sv
hdl/isrp_if.sv
hdl/isrp_front.sv
hdl/isrp_queue.sv
hdl/isrp_back.sv
hdl/imu_sensor_report_parser_top.sv
tb/testbench.sv
